@@ sv/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared types and constants for the controller, the datapath and the checker.
// ----------------------------------------------------------------------------
package bba_pkg;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_ZERO      = 3'd1,
    STAT_TOO_LARGE = 3'd2,
    STAT_NO_SPACE  = 3'd3,
    STAT_BAD_FREE  = 3'd4
  } stat_t;

  localparam logic [1:0] REG_LEVELS = 2'd0;
  localparam logic [1:0] REG_HEADER = 2'd1;
  localparam logic [1:0] REG_POOL   = 2'd2;

  localparam logic [3:0]  LEVELS_RESET = 4'd11;
  localparam logic [7:0]  HEADER_RESET = 8'd48;
  localparam logic [31:0] POOL_RESET   = 32'd65536;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_SWEEP,
    OP_LOAD,
    OP_FAIL,
    OP_WANT_INC,
    OP_SINIT,
    OP_SRD,
    OP_STAKE,
    OP_WORD_NEXT,
    OP_LV_NEXT,
    OP_SPLIT,
    OP_SSET,
    OP_ARD,
    OP_AWR,
    OP_FRD,
    OP_FTAKE,
    OP_MRD,
    OP_MMERGE,
    OP_MSRD,
    OP_MSWR,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    stat_t  code;
  } dp_cmd_t;

  typedef struct packed {
    logic restart;
    logic sweep_last;
    logic kind;
    logic req_zero;
    logic too_large;
    logic bidx_bad;
    logic want_ge_l;
    logic size_short;
    logic hit;
    logic word_last;
    logic lv_top;
    logic lv_gt_want;
    logic astart_bit;
    logic buddy_bit;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SIZE,
    S_SRD,
    S_SCHK,
    S_SPLIT,
    S_SSET,
    S_AWR,
    S_FCHK,
    S_MRD,
    S_MCHK,
    S_MSWR,
    S_DONE
  } state_t;

endpackage

@@ sv/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator controller
// Sequences the datapath through sizing, search, split, merge and clearing.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bba_pkg::dp_stat_t stat,
  output bba_pkg::dp_cmd_t  cmd
);
  import bba_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    cmd.code  = STAT_OK;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_SWEEP;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.kind) begin
          if (stat.req_zero) begin
            cmd.op    = OP_FAIL;
            cmd.code  = STAT_ZERO;
            state_nxt = S_DONE;
          end else if (stat.too_large) begin
            cmd.op    = OP_FAIL;
            cmd.code  = STAT_TOO_LARGE;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SIZE;
          end
        end else if (stat.bidx_bad) begin
          cmd.op    = OP_FAIL;
          cmd.code  = STAT_BAD_FREE;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_FRD;
          state_nxt = S_FCHK;
        end
      end
      S_SIZE: begin
        if (stat.want_ge_l) begin
          cmd.op    = OP_FAIL;
          cmd.code  = STAT_NO_SPACE;
          state_nxt = S_DONE;
        end else if (stat.size_short) begin
          cmd.op = OP_WANT_INC;
        end else begin
          cmd.op    = OP_SINIT;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        cmd.op    = OP_SRD;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (stat.hit) begin
          cmd.op    = OP_STAKE;
          state_nxt = S_SPLIT;
        end else if (!stat.word_last) begin
          cmd.op    = OP_WORD_NEXT;
          state_nxt = S_SRD;
        end else if (stat.lv_top) begin
          cmd.op    = OP_FAIL;
          cmd.code  = STAT_NO_SPACE;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_LV_NEXT;
          state_nxt = S_SRD;
        end
      end
      S_SPLIT: begin
        if (stat.lv_gt_want) begin
          cmd.op    = OP_SPLIT;
          state_nxt = S_SSET;
        end else begin
          cmd.op    = OP_ARD;
          state_nxt = S_AWR;
        end
      end
      S_SSET: begin
        cmd.op    = OP_SSET;
        state_nxt = S_SPLIT;
      end
      S_AWR: begin
        cmd.op    = OP_AWR;
        state_nxt = S_DONE;
      end
      S_FCHK: begin
        if (!stat.astart_bit) begin
          cmd.op    = OP_FAIL;
          cmd.code  = STAT_BAD_FREE;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_FTAKE;
          state_nxt = S_MRD;
        end
      end
      S_MRD: begin
        if (!stat.lv_top) begin
          cmd.op    = OP_MRD;
          state_nxt = S_MCHK;
        end else begin
          cmd.op    = OP_MSRD;
          state_nxt = S_MSWR;
        end
      end
      S_MCHK: begin
        if (stat.buddy_bit) begin
          cmd.op    = OP_MMERGE;
          state_nxt = S_MRD;
        end else begin
          cmd.op    = OP_MSRD;
          state_nxt = S_MSWR;
        end
      end
      S_MSWR: begin
        cmd.op    = OP_MSWR;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    if (stat.restart) state_nxt = S_CLEAR;
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

@@ sv/bba_dp.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator datapath
// Holds the configuration, the free map, allocation marks and the output word.
// ----------------------------------------------------------------------------
module bba_dp #(
  parameter int GRANULE_LOG2 = 6,
  parameter int LEVELS       = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_kind,
  input  logic [31:0]       in_request_bytes,
  input  logic [9:0]        in_block_index,
  input  bba_pkg::dp_cmd_t  cmd,
  output bba_pkg::dp_stat_t stat,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [9:0]        out_granted_index,
  output logic [3:0]        out_granted_level
);
  import bba_pkg::*;

  localparam int NGRAN    = 1 << (LEVELS - 1);
  localparam int WB_LOG2  = (LEVELS - 1 >= 6) ? 5 : LEVELS - 2;
  localparam int WB       = 1 << WB_LOG2;
  localparam int WPL_LOG2 = LEVELS - 1 - WB_LOG2;
  localparam int WPL      = 1 << WPL_LOG2;
  localparam int FDEPTH   = LEVELS * WPL;
  localparam int FA_W     = $clog2(FDEPTH);
  localparam int BIT_W    = (WB_LOG2 > 0) ? WB_LOG2 : 1;
  localparam int GI_W     = LEVELS - 1;
  localparam int LW       = $clog2(LEVELS + 1);
  localparam int SZ_W     = (GRANULE_LOG2 + LEVELS > 33) ? GRANULE_LOG2 + LEVELS : 33;

  function automatic logic [FA_W-1:0] faddr(input logic [LW-1:0] lv,
                                            input logic [GI_W-1:0] j);
    faddr = FA_W'((32'(lv) << WPL_LOG2) + (32'(j) >> WB_LOG2));
  endfunction

  function automatic logic [FA_W-1:0] faddr_w(input logic [LW-1:0] lv,
                                              input logic [WPL_LOG2-1:0] w);
    faddr_w = FA_W'((32'(lv) << WPL_LOG2) + 32'(w));
  endfunction

  function automatic logic [WPL_LOG2-1:0] gword(input logic [GI_W-1:0] g);
    gword = WPL_LOG2'(32'(g) >> WB_LOG2);
  endfunction

  function automatic logic [BIT_W-1:0] bpos(input logic [GI_W-1:0] j);
    bpos = BIT_W'(32'(j) % WB);
  endfunction

  function automatic logic [WB-1:0] onehot(input logic [BIT_W-1:0] b);
    onehot = WB'(1) << b;
  endfunction

  // Configuration registers.
  logic [3:0]  levels_r, levels_nxt;
  logic [7:0]  header_r, header_nxt;
  logic [31:0] pool_r, pool_nxt;
  logic        restart;
  logic [LW-1:0] eff_l;

  always_comb begin
    levels_nxt = levels_r;
    header_nxt = header_r;
    pool_nxt   = pool_r;
    restart    = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_LEVELS: begin
          levels_nxt = cfg_wdata[3:0];
          restart    = 1'b1;
        end
        REG_HEADER: header_nxt = cfg_wdata[7:0];
        REG_POOL:   pool_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (levels_r == 4'd0) begin
      eff_l = LW'(1);
    end else if (32'(levels_r) > LEVELS) begin
      eff_l = LW'(LEVELS);
    end else begin
      eff_l = LW'(levels_r);
    end
  end

  // Memories.
  logic [WB-1:0] fm_mem [FDEPTH];
  logic [WB-1:0] as_mem [WPL];
  logic [LW-1:0] al_mem [NGRAN];

  logic                fm_we, fm_re, as_we, as_re, al_we, al_re;
  logic [FA_W-1:0]     fm_waddr, fm_raddr;
  logic [WB-1:0]       fm_wdata, as_wdata;
  logic [WPL_LOG2-1:0] as_waddr, as_raddr;
  logic [GI_W-1:0]     al_waddr, al_raddr;
  logic [LW-1:0]       al_wdata;
  logic [WB-1:0]       fm_rdata_r, as_rdata_r;
  logic [LW-1:0]       al_rdata_r;

  always_ff @(posedge clk) begin
    if (fm_we) fm_mem[fm_waddr] <= fm_wdata;
    if (fm_re) fm_rdata_r <= fm_mem[fm_raddr];
  end

  always_ff @(posedge clk) begin
    if (as_we) as_mem[as_waddr] <= as_wdata;
    if (as_re) as_rdata_r <= as_mem[as_raddr];
  end

  always_ff @(posedge clk) begin
    if (al_we) al_mem[al_waddr] <= al_wdata;
    if (al_re) al_rdata_r <= al_mem[al_raddr];
  end

  // Item registers.
  logic            kind_r, kind_nxt;
  logic            req_zero_r, req_zero_nxt;
  logic [SZ_W-1:0] need_r, need_nxt;
  logic [9:0]      bidx_r, bidx_nxt;
  logic [LW-1:0]   want_r, want_nxt;
  logic [LW-1:0]   lv_r, lv_nxt;
  logic [GI_W-1:0] j_r, j_nxt;
  logic [WPL_LOG2-1:0] word_r, word_nxt;
  logic [FA_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]      res_status_r, res_status_nxt;
  logic [9:0]      res_idx_r, res_idx_nxt;
  logic [3:0]      res_lv_r, res_lv_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [2:0]      out_status_r, out_status_nxt;
  logic [9:0]      out_idx_r, out_idx_nxt;
  logic [3:0]      out_lv_r, out_lv_nxt;

  logic [GI_W-1:0]     bidx_g, gran, j_pe, j_buddy, j_odd;
  logic [BIT_W-1:0]    pe;
  logic [WPL_LOG2-1:0] last_word;
  logic [LW-1:0]       lv_clip;
  logic [FA_W-1:0]     top_addr;

  assign bidx_g   = GI_W'(bidx_r);
  assign gran     = j_r << lv_r;
  assign j_buddy  = j_r ^ GI_W'(1);
  assign j_odd    = GI_W'((32'(j_r) << 1) | 32'd1);
  assign j_pe     = GI_W'((32'(word_r) << WB_LOG2) + 32'(pe));
  assign top_addr = faddr(LW'(32'(eff_l) - 32'd1), '0);
  assign last_word = WPL_LOG2'((((32'd1 << (32'(eff_l) - 32'd1 - 32'(lv_r))) - 32'd1)
                               >> WB_LOG2));
  assign lv_clip  = (32'(al_rdata_r) > 32'(eff_l) - 32'd1) ?
                    LW'(32'(eff_l) - 32'd1) : al_rdata_r;

  always_comb begin
    pe = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (fm_rdata_r[i]) pe = BIT_W'(i);
    end
  end

  always_comb begin
    kind_nxt       = kind_r;
    req_zero_nxt   = req_zero_r;
    need_nxt       = need_r;
    bidx_nxt       = bidx_r;
    want_nxt       = want_r;
    lv_nxt         = lv_r;
    j_nxt          = j_r;
    word_nxt       = word_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_lv_nxt     = res_lv_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_lv_nxt     = out_lv_r;
    out_valid_nxt  = out_valid_r && out_stall;
    fm_we = 1'b0; fm_re = 1'b0; as_we = 1'b0; as_re = 1'b0; al_we = 1'b0; al_re = 1'b0;
    fm_waddr = '0; fm_raddr = '0; fm_wdata = '0;
    as_waddr = '0; as_raddr = '0; as_wdata = '0;
    al_waddr = '0; al_raddr = '0; al_wdata = '0;
    unique case (cmd.op)
      OP_NONE: ;
      OP_SWEEP: begin
        fm_we    = 1'b1;
        fm_waddr = cnt_r;
        fm_wdata = (cnt_r == top_addr) ? WB'(1) : '0;
        as_we    = (32'(cnt_r) < WPL);
        as_waddr = WPL_LOG2'(cnt_r);
        as_wdata = '0;
        cnt_nxt  = FA_W'(32'(cnt_r) + 32'd1);
      end
      OP_LOAD: begin
        kind_nxt     = in_kind;
        req_zero_nxt = (in_request_bytes == 32'd0);
        need_nxt     = SZ_W'(in_request_bytes) + SZ_W'(header_r);
        bidx_nxt     = in_block_index;
        want_nxt     = '0;
      end
      OP_FAIL: begin
        res_status_nxt = cmd.code;
        res_idx_nxt    = (cmd.code == STAT_BAD_FREE) ? bidx_r : 10'd0;
        res_lv_nxt     = 4'd0;
      end
      OP_WANT_INC: want_nxt = LW'(32'(want_r) + 32'd1);
      OP_SINIT: begin
        lv_nxt   = want_r;
        word_nxt = '0;
      end
      OP_SRD: begin
        fm_re    = 1'b1;
        fm_raddr = faddr_w(lv_r, word_r);
      end
      OP_STAKE: begin
        fm_we    = 1'b1;
        fm_waddr = faddr_w(lv_r, word_r);
        fm_wdata = fm_rdata_r & ~onehot(pe);
        j_nxt    = j_pe;
      end
      OP_WORD_NEXT: word_nxt = WPL_LOG2'(32'(word_r) + 32'd1);
      OP_LV_NEXT: begin
        lv_nxt   = LW'(32'(lv_r) + 32'd1);
        word_nxt = '0;
      end
      OP_SPLIT: begin
        lv_nxt   = LW'(32'(lv_r) - 32'd1);
        j_nxt    = GI_W'(32'(j_r) << 1);
        fm_re    = 1'b1;
        fm_raddr = faddr(LW'(32'(lv_r) - 32'd1), j_odd);
      end
      OP_SSET: begin
        fm_we    = 1'b1;
        fm_waddr = faddr(lv_r, j_r | GI_W'(1));
        fm_wdata = fm_rdata_r | onehot(bpos(j_r | GI_W'(1)));
      end
      OP_ARD: begin
        as_re    = 1'b1;
        as_raddr = gword(gran);
      end
      OP_AWR: begin
        as_we          = 1'b1;
        as_waddr       = gword(gran);
        as_wdata       = as_rdata_r | onehot(bpos(gran));
        al_we          = 1'b1;
        al_waddr       = gran;
        al_wdata       = lv_r;
        res_status_nxt = STAT_OK;
        res_idx_nxt    = 10'(gran);
        res_lv_nxt     = 4'(lv_r);
      end
      OP_FRD: begin
        as_re    = 1'b1;
        as_raddr = gword(bidx_g);
        al_re    = 1'b1;
        al_raddr = bidx_g;
      end
      OP_FTAKE: begin
        as_we    = 1'b1;
        as_waddr = gword(bidx_g);
        as_wdata = as_rdata_r & ~onehot(bpos(bidx_g));
        lv_nxt   = lv_clip;
        j_nxt    = bidx_g >> lv_clip;
      end
      OP_MRD: begin
        fm_re    = 1'b1;
        fm_raddr = faddr(lv_r, j_buddy);
      end
      OP_MMERGE: begin
        fm_we    = 1'b1;
        fm_waddr = faddr(lv_r, j_buddy);
        fm_wdata = fm_rdata_r & ~onehot(bpos(j_buddy));
        j_nxt    = j_r >> 1;
        lv_nxt   = LW'(32'(lv_r) + 32'd1);
      end
      OP_MSRD: begin
        fm_re    = 1'b1;
        fm_raddr = faddr(lv_r, j_r);
      end
      OP_MSWR: begin
        fm_we          = 1'b1;
        fm_waddr       = faddr(lv_r, j_r);
        fm_wdata       = fm_rdata_r | onehot(bpos(j_r));
        res_status_nxt = STAT_OK;
        res_idx_nxt    = 10'(gran);
        res_lv_nxt     = 4'(lv_r);
      end
      OP_OUT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = res_status_r;
        out_idx_nxt    = res_idx_r;
        out_lv_nxt     = res_lv_r;
      end
      default: ;
    endcase
    if (restart) cnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r    <= LEVELS_RESET;
      header_r    <= HEADER_RESET;
      pool_r      <= POOL_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      levels_r    <= levels_nxt;
      header_r    <= header_nxt;
      pool_r      <= pool_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    req_zero_r   <= req_zero_nxt;
    need_r       <= need_nxt;
    bidx_r       <= bidx_nxt;
    want_r       <= want_nxt;
    lv_r         <= lv_nxt;
    j_r          <= j_nxt;
    word_r       <= word_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_lv_r     <= res_lv_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_lv_r     <= out_lv_nxt;
  end

  always_comb begin
    stat.restart    = restart;
    stat.sweep_last = (32'(cnt_r) == FDEPTH - 1);
    stat.kind       = kind_r;
    stat.req_zero   = req_zero_r;
    stat.too_large  = (need_r > SZ_W'(pool_r));
    stat.bidx_bad   = (32'(bidx_r) >= NGRAN);
    stat.want_ge_l  = (want_r >= eff_l);
    stat.size_short = ((SZ_W'(1) << (GRANULE_LOG2 + 32'(want_r))) < need_r);
    stat.hit        = |fm_rdata_r;
    stat.word_last  = (word_r == last_word);
    stat.lv_top     = (32'(lv_r) + 32'd1 >= 32'(eff_l));
    stat.lv_gt_want = (lv_r > want_r);
    stat.astart_bit = as_rdata_r[bpos(bidx_g)];
    stat.buddy_bit  = fm_rdata_r[bpos(j_buddy)];
    stat.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_idx_r;
  assign out_granted_level = out_lv_r;

endmodule

@@ sv/buddy_block_allocator.sv @@
// An allocate runs through the sizing steps, a scan of the free-map words and one
//   split per level; a free runs through one merge per level.
// Words are taken one at a time; the free-map memory port sets the rate.
// Reset and any write of levels_in_use run a clearing pass over the free map
//   before the next word is accepted.
// ----------------------------------------------------------------------------
// Buddy block allocator top level
// Binary buddy allocator over a pool of granules, split and merged per level.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
  parameter int GRANULE_LOG2 = 6,
  parameter int LEVELS       = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [31:0] in_request_bytes,
  input  logic [9:0]  in_block_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [9:0]  out_granted_index,
  output logic [3:0]  out_granted_level
);
  import bba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_dp #(
    .GRANULE_LOG2 (GRANULE_LOG2),
    .LEVELS       (LEVELS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_kind           (in_kind),
    .in_request_bytes  (in_request_bytes),
    .in_block_index    (in_block_index),
    .cmd               (cmd),
    .stat              (stat),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_granted_level (out_granted_level)
  );

endmodule

@@ sv/bba_checker.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module bba_assert (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [9:0]  out_granted_index,
  input logic [3:0]  out_granted_level
);
  import bba_pkg::*;

  // The result word must hold while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_granted_index) && $stable(out_granted_level))
    else $error("stalled result word changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while one is in work");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_ZERO || out_status == STAT_TOO_LARGE ||
      out_status == STAT_NO_SPACE) |-> out_granted_index == 10'd0 &&
      out_granted_level == 4'd0)
    else $error("failed allocate returned a block");

  a_bad_free_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_BAD_FREE |-> out_granted_level == 4'd0)
    else $error("bad free returned a level");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("block not idle after reset");

endmodule

bind buddy_block_allocator bba_assert u_bba_assert (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_granted_index (out_granted_index),
  .out_granted_level (out_granted_level)
);

@@ bench/bba_checker.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator checker
// Watches the configuration port and both channels, keeps its own copy of the
// free map and the allocation records, predicts the result word of every
// accepted input word and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module bba_checker
  import bba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic [31:0] in_request_bytes,
  input  logic [9:0]  in_block_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [9:0]  out_granted_index,
  input  logic [3:0]  out_granted_level,
  output int          fail_count,
  output int          pending_count
);

  localparam int NUM_LEVELS = 11;
  localparam int GRAN_LOG2  = 6;
  localparam int NUM_GRAN   = 1 << (NUM_LEVELS - 1);
  localparam int NUM_NODES  = (1 << NUM_LEVELS) - 1;

  typedef struct packed {
    stat_t      status;
    logic [9:0] index;
    logic [3:0] level;
  } grant_t;

  logic       free_map [NUM_NODES];
  logic       alloc_start [NUM_GRAN];
  logic [3:0] alloc_level [NUM_GRAN];
  logic [3:0] levels_reg;
  logic [7:0] header_reg;
  logic [31:0] pool_reg;
  grant_t     grant_q [$];

  assign pending_count = grant_q.size();

  function automatic int levels_eff();
    if (levels_reg == 4'd0) return 1;
    if (levels_reg > NUM_LEVELS) return NUM_LEVELS;
    return int'(levels_reg);
  endfunction

  function automatic int node_at(int lv, int j);
    return ((1 << (NUM_LEVELS - 1 - lv)) - 1) + j;
  endfunction

  task automatic clear_pool();
    for (int n = 0; n < NUM_NODES; n++) free_map[n] = 1'b0;
    for (int g = 0; g < NUM_GRAN; g++) begin
      alloc_start[g] = 1'b0;
      alloc_level[g] = 4'd0;
    end
    free_map[node_at(levels_eff() - 1, 0)] = 1'b1;
  endtask

  task automatic predict_grant(input logic kind, input logic [31:0] req,
                               input logic [9:0] bidx, output grant_t g);
    int L, want, lv, j;
    logic [63:0] need;
    logic found;
    L = levels_eff();
    g = '{STAT_OK, 10'd0, 4'd0};
    found = 1'b0;
    j = 0;
    lv = 0;
    if (kind == 1'b0) begin
      need = {32'd0, req} + {56'd0, header_reg};
      want = 0;
      if (req == 32'd0) begin
        g.status = STAT_ZERO;
      end else if (need > {32'd0, pool_reg}) begin
        g.status = STAT_TOO_LARGE;
      end else begin
        while (want < L && (64'd1 << (GRAN_LOG2 + want)) < need) want++;
        if (want < L) begin
          for (lv = want; lv < L; lv++) begin
            for (j = 0; j < (1 << (L - 1 - lv)); j++) begin
              if (free_map[node_at(lv, j)]) begin
                found = 1'b1;
                break;
              end
            end
            if (found) break;
          end
        end
        if (!found) begin
          g.status = STAT_NO_SPACE;
        end else begin
          free_map[node_at(lv, j)] = 1'b0;
          while (lv > want) begin
            lv--;
            j = j << 1;
            free_map[node_at(lv, j + 1)] = 1'b1;
          end
          alloc_start[j << lv] = 1'b1;
          alloc_level[j << lv] = lv[3:0];
          g.index = 10'(j << lv);
          g.level = lv[3:0];
        end
      end
    end else begin
      if (!alloc_start[bidx]) begin
        g.status = STAT_BAD_FREE;
        g.index = bidx;
      end else begin
        lv = int'(alloc_level[bidx]);
        if (lv > L - 1) lv = L - 1;
        alloc_start[bidx] = 1'b0;
        j = int'(bidx) >> lv;
        while (lv < L - 1 && free_map[node_at(lv, j ^ 1)]) begin
          free_map[node_at(lv, j ^ 1)] = 1'b0;
          j = j >> 1;
          lv++;
        end
        free_map[node_at(lv, j)] = 1'b1;
        g.index = 10'(j << lv);
        g.level = lv[3:0];
      end
    end
  endtask

  always @(posedge clk) begin
    grant_t g, exp_g;
    if (!rst_n) begin
      levels_reg = LEVELS_RESET;
      header_reg = HEADER_RESET;
      pool_reg = POOL_RESET;
      clear_pool();
      grant_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEVELS: begin
            levels_reg = cfg_wdata[3:0];
            clear_pool();
          end
          REG_HEADER: header_reg = cfg_wdata[7:0];
          REG_POOL: pool_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_grant(in_kind, in_request_bytes, in_block_index, g);
        grant_q.push_back(g);
      end
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          if (fail_count < 10)
            $display("checker: unexpected word status=%0d index=%0d level=%0d",
                     out_status, out_granted_index, out_granted_level);
          fail_count <= fail_count + 1;
        end else begin
          exp_g = grant_q.pop_front();
          if (out_status !== exp_g.status || out_granted_index !== exp_g.index ||
              out_granted_level !== exp_g.level) begin
            if (fail_count < 10)
              $display("checker: mismatch expected %0d/%0d/%0d actual %0d/%0d/%0d",
                       exp_g.status, exp_g.index, exp_g.level,
                       out_status, out_granted_index, out_granted_level);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ bench/buddy_block_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives directed and random allocate and free words through several register
// settings and idle patterns; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module buddy_block_allocator_tb;
  import bba_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [31:0] in_request_bytes;
  logic [9:0]  in_block_index;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [9:0]  out_granted_index;
  logic [3:0]  out_granted_level;
  int          fail_count;
  int          pending_count;
  int          idle_pct;
  int          stall_pct;
  int          top_level;
  logic        kind_q [$];
  logic [9:0]  live_q [$];

  buddy_block_allocator uut (.*);
  bba_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #12000000;
    $display("[buddy_block_allocator] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    logic k;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
    if (rst_n) begin
      if (in_valid && !in_stall) kind_q.push_back(in_kind);
      if (out_valid && !out_stall && kind_q.size() > 0) begin
        k = kind_q.pop_front();
        if (!k && out_status == STAT_OK) live_q.push_back(out_granted_index);
      end
    end
  end

  task automatic send_word(input logic kind, input logic [31:0] req, input logic [9:0] bidx);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_request_bytes <= req;
    in_block_index <= bidx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic free_live();
    int k;
    if (live_q.size() == 0) begin
      send_word(1'b1, $urandom, 10'($urandom));
    end else begin
      k = $urandom_range(0, live_q.size() - 1);
      send_word(1'b1, $urandom, live_q[k]);
      live_q.delete(k);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [3:0] lv, input logic [7:0] hdr, input logic [31:0] pool);
    drain();
    write_reg(REG_POOL, pool);
    write_reg(REG_HEADER, hdr);
    write_reg(REG_LEVELS, {28'd0, lv});
    cfg_we <= 1'b0;
    live_q.delete();
    if (lv == 4'd0) top_level = 1;
    else if (lv > 4'd11) top_level = 11;
    else top_level = int'(lv);
  endtask

  task automatic random_words(input int count);
    int sz;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain();
      case ($urandom_range(0, 19))
        0: send_word(1'b0, $urandom, 10'($urandom));
        1: send_word(1'b1, $urandom, 10'($urandom));
        2: send_word(1'b0, 32'd0, 10'($urandom));
        default: begin
          if (live_q.size() > 0 && $urandom_range(0, 99) < 45) begin
            free_live();
          end else begin
            sz = $urandom_range(0, top_level - 1);
            send_word(1'b0, $urandom_range(1, 64 << sz), 10'($urandom));
          end
        end
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_LEVELS;
    cfg_wdata = 32'd0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_request_bytes = 32'd0;
    in_block_index = 10'd0;
    out_stall = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    top_level = 11;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(1'b0, 32'd0, 10'd0);
    send_word(1'b0, 32'hFFFF_FFFF, 10'd0);
    send_word(1'b0, 32'd65488, 10'd0);
    send_word(1'b0, 32'd16, 10'd0);
    send_word(1'b0, 32'd17, 10'd0);
    send_word(1'b0, 32'd65488, 10'd0);
    send_word(1'b1, 32'd0, 10'd1023);
    send_word(1'b1, 32'd0, 10'd5);
    drain();
    free_live();
    free_live();
    free_live();
    send_word(1'b0, 32'd65488, 10'd0);
    drain();
    free_live();
    set_regs(4'd11, 8'd0, 32'hFFFF_FFFF);
    send_word(1'b0, 32'hFFFF_FFFF, 10'd0);
    send_word(1'b0, 32'd65536, 10'd0);
    send_word(1'b0, 32'd65537, 10'd0);
    send_word(1'b0, 32'd64, 10'd0);
    send_word(1'b0, 32'd65, 10'd0);
    drain();
    free_live();
    free_live();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(4'd11, 8'd48, 32'd65536);
        1: set_regs(4'd1, 8'd0, 32'd64);
        2: set_regs(4'd15, 8'd255, 32'hFFFF_FFFF);
        3: set_regs(4'd0, 8'd10, 32'd200);
        4: set_regs(4'd5, 8'd20, 32'd2000);
        default: set_regs(4'd11, 8'd1, 32'd40000);
      endcase
      for (int m = 0; m < 4; m++) begin
        case (m)
          0: begin idle_pct = 0; stall_pct = 0; end
          1: begin idle_pct = 51; stall_pct = 0; end
          2: begin idle_pct = 0; stall_pct = 51; end
          default: begin idle_pct = 24; stall_pct = 24; end
        endcase
        random_words(45);
      end
    end

    idle_pct = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    stall_pct = 0;
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("[buddy_block_allocator] OK");
    end else begin
      $display("[buddy_block_allocator] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/bba_pkg.sv
sv/bba_ctrl.sv
sv/bba_dp.sv
sv/buddy_block_allocator.sv
sv/bba_checker.sv
bench/bba_checker.sv
bench/buddy_block_allocator_tb.sv
